// ===== rtl/bhi_pkg.sv =====
// Shared widths, types and constants for the barycentric height interpolator.
`timescale 1ns / 1ps

package bhi_pkg;

  // Field and datapath widths
  localparam int unsigned CoordW = 32;          // Q16.16 coordinates and heights
  localparam int unsigned DiffW  = CoordW + 1;  // exact coordinate differences
  localparam int unsigned ProdW  = 2 * DiffW;   // difference products
  localparam int unsigned SumW   = ProdW + 1;   // determinant and numerators
  localparam int unsigned QuoW   = 64;          // Q31.32 weights
  localparam int unsigned HalfQW = QuoW / 2;    // fraction bits of a weight
  localparam int unsigned WideW  = QuoW + CoordW;  // one weight times one height
  localparam int unsigned AccW   = WideW + 2;      // sum of three such products

  // Pipeline depth of each part
  localparam int unsigned FrontStages = 4;
  localparam int unsigned DivSteps    = QuoW;
  localparam int unsigned DivStages   = DivSteps + 1;
  localparam int unsigned BlendStages = 6;
  localparam int unsigned Latency     = FrontStages + DivStages + BlendStages;

  typedef logic signed [CoordW-1:0] coord_t;

  // One input item
  typedef struct packed {
    coord_t ax, ah, az;
    coord_t bx, bh, bz;
    coord_t cx, ch, cz;
    coord_t qx, qz;
  } tri_t;

  // Vertex heights that ride alongside the weights
  typedef struct packed {
    coord_t ah, bh, ch;
  } heights_t;

  // Front end to divider
  typedef struct packed {
    logic [SumW-1:0] num1_mag;
    logic [SumW-1:0] num2_mag;
    logic [SumW-1:0] den_mag;
    logic            neg1;
    logic            neg2;
    logic            det_zero;
    heights_t        hgt;
  } div_in_t;

  // Divider to blend stage
  typedef struct packed {
    logic [QuoW-1:0] quo1;
    logic [QuoW-1:0] quo2;
    logic            ovf1;
    logic            ovf2;
    logic            neg1;
    logic            neg2;
    logic            det_zero;
    heights_t        hgt;
  } div_out_t;

endpackage

// ===== rtl/bhi_front.sv =====
// Front end: coordinate differences, cross products, determinant and numerator magnitudes.
`timescale 1ns / 1ps

module bhi_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bhi_pkg::tri_t    in_i,
  output logic             out_valid_o,
  output bhi_pkg::div_in_t out_o
);
  import bhi_pkg::*;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef struct packed {
    diff_t    bzc, cxb, axc, azc, cza, qxc, qzc;
    heights_t hgt;
  } s1_t;

  typedef struct packed {
    prod_t    p1, p2, p3, p4, p5, p6;
    heights_t hgt;
  } s2_t;

  typedef struct packed {
    sum_t     det, n1, n2;
    heights_t hgt;
  } s3_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  div_in_t s4_d, s4_q;
  logic [FrontStages-1:0] vld_q;

  // Form exact differences
  always_comb begin
    s1_d.bzc = DiffW'(in_i.bz) - DiffW'(in_i.cz);
    s1_d.cxb = DiffW'(in_i.cx) - DiffW'(in_i.bx);
    s1_d.axc = DiffW'(in_i.ax) - DiffW'(in_i.cx);
    s1_d.azc = DiffW'(in_i.az) - DiffW'(in_i.cz);
    s1_d.cza = DiffW'(in_i.cz) - DiffW'(in_i.az);
    s1_d.qxc = DiffW'(in_i.qx) - DiffW'(in_i.cx);
    s1_d.qzc = DiffW'(in_i.qz) - DiffW'(in_i.cz);
    s1_d.hgt.ah = in_i.ah;
    s1_d.hgt.bh = in_i.bh;
    s1_d.hgt.ch = in_i.ch;
  end

  // Multiply the difference pairs
  always_comb begin
    s2_d.p1  = prod_t'(s1_q.bzc) * prod_t'(s1_q.axc);
    s2_d.p2  = prod_t'(s1_q.cxb) * prod_t'(s1_q.azc);
    s2_d.p3  = prod_t'(s1_q.bzc) * prod_t'(s1_q.qxc);
    s2_d.p4  = prod_t'(s1_q.cxb) * prod_t'(s1_q.qzc);
    s2_d.p5  = prod_t'(s1_q.cza) * prod_t'(s1_q.qxc);
    s2_d.p6  = prod_t'(s1_q.axc) * prod_t'(s1_q.qzc);
    s2_d.hgt = s1_q.hgt;
  end

  // Add product pairs
  always_comb begin
    s3_d.det = sum_t'(s2_q.p1) + sum_t'(s2_q.p2);
    s3_d.n1  = sum_t'(s2_q.p3) + sum_t'(s2_q.p4);
    s3_d.n2  = sum_t'(s2_q.p5) + sum_t'(s2_q.p6);
    s3_d.hgt = s2_q.hgt;
  end

  // Split into magnitudes and quotient signs
  always_comb begin
    s4_d.den_mag  = s3_q.det[SumW-1] ? SumW'(-s3_q.det) : SumW'(s3_q.det);
    s4_d.num1_mag = s3_q.n1[SumW-1]  ? SumW'(-s3_q.n1)  : SumW'(s3_q.n1);
    s4_d.num2_mag = s3_q.n2[SumW-1]  ? SumW'(-s3_q.n2)  : SumW'(s3_q.n2);
    s4_d.neg1     = s3_q.n1[SumW-1] ^ s3_q.det[SumW-1];
    s4_d.neg2     = s3_q.n2[SumW-1] ^ s3_q.det[SumW-1];
    s4_d.det_zero = (s3_q.det == '0);
    s4_d.hgt      = s3_q.hgt;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontStages-2:0], in_valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
  end

  assign out_valid_o = vld_q[FrontStages-1];
  assign out_o       = s4_q;

endmodule

// ===== rtl/bhi_divider.sv =====
// Pipelined restoring divider: two Q.32 quotients over a shared denominator, one bit a stage.
`timescale 1ns / 1ps

module bhi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bhi_pkg::div_in_t  in_i,
  output logic              out_valid_o,
  output bhi_pkg::div_out_t out_o
);
  import bhi_pkg::*;

  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [QuoW-1:0] qn;   // dividend bits shift out the top, quotient bits in at the bottom
    logic            ovf;
    logic            neg;
  } lane_t;

  typedef struct packed {
    lane_t           l1;
    lane_t           l2;
    logic [SumW-1:0] den;
    logic            det_zero;
    heights_t        hgt;
  } step_t;

  // Seed a lane: quotient bits above the weight width are caught by one compare
  function automatic lane_t lane_init(logic [SumW-1:0] num, logic [SumW-1:0] den,
                                      logic neg);
    lane_t           r;
    logic [SumW-1:0] top;
    top   = num >> HalfQW;
    r.rem = top;
    r.ovf = (top >= den);
    r.qn  = {num[HalfQW-1:0], {HalfQW{1'b0}}};
    r.neg = neg;
    return r;
  endfunction

  // One restoring step
  function automatic lane_t lane_step(lane_t l, logic [SumW-1:0] den);
    lane_t         r;
    logic [SumW:0] trial;
    logic          take;
    trial = {l.rem, l.qn[QuoW-1]};
    take  = (trial >= {1'b0, den});
    r     = l;
    r.rem = take ? SumW'(trial - {1'b0, den}) : trial[SumW-1:0];
    r.qn  = {l.qn[QuoW-2:0], take};
    return r;
  endfunction

  step_t                stage_q [DivStages];
  step_t                stage_d [DivStages];
  step_t                seed_d;
  logic [DivStages-1:0] vld_q;

  // Seed both lanes
  always_comb begin
    seed_d.l1       = lane_init(in_i.num1_mag, in_i.den_mag, in_i.neg1);
    seed_d.l2       = lane_init(in_i.num2_mag, in_i.den_mag, in_i.neg2);
    seed_d.den      = in_i.den_mag;
    seed_d.det_zero = in_i.det_zero;
    seed_d.hgt      = in_i.hgt;
  end

  // Form the next value of every step
  always_comb begin
    stage_d[0] = seed_d;
    for (int i = 1; i < DivStages; i++) begin
      stage_d[i]    = stage_q[i-1];
      stage_d[i].l1 = lane_step(stage_q[i-1].l1, stage_q[i-1].den);
      stage_d[i].l2 = lane_step(stage_q[i-1].l2, stage_q[i-1].den);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivStages-2:0], in_valid_i};
    end
  end

  // Advance payload through the step chain
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DivStages; i++) begin
      stage_q[i] <= stage_d[i];
    end
  end

  always_comb begin
    out_o.quo1     = stage_q[DivStages-1].l1.qn;
    out_o.quo2     = stage_q[DivStages-1].l2.qn;
    out_o.ovf1     = stage_q[DivStages-1].l1.ovf;
    out_o.ovf2     = stage_q[DivStages-1].l2.ovf;
    out_o.neg1     = stage_q[DivStages-1].l1.neg;
    out_o.neg2     = stage_q[DivStages-1].l2.neg;
    out_o.det_zero = stage_q[DivStages-1].det_zero;
    out_o.hgt      = stage_q[DivStages-1].hgt;
  end

  assign out_valid_o = vld_q[DivStages-1];

  // A lane that did not overflow keeps its remainder below the denominator
  a_seed_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !stage_q[0].l1.ovf |-> stage_q[0].l1.rem < stage_q[0].den)
    else $error("seeded remainder not below denominator");

  a_final_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.ovf1 && !out_o.ovf2 |->
      stage_q[DivStages-1].l1.rem < stage_q[DivStages-1].den &&
      stage_q[DivStages-1].l2.rem < stage_q[DivStages-1].den)
    else $error("final remainder not below denominator");

  a_zero_den_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.det_zero |-> out_o.ovf1 && out_o.ovf2)
    else $error("zero denominator not flagged as overflow");

endmodule

// ===== rtl/bhi_blend.sv =====
// Blend: saturate weights, form the third weight, weight the heights, saturate the sum and zero a degenerate result.
`timescale 1ns / 1ps

module bhi_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bhi_pkg::div_out_t in_i,
  output logic              out_valid_o,
  output bhi_pkg::coord_t   height_o,
  output logic              valid_res_o
);
  import bhi_pkg::*;

  typedef logic signed [QuoW-1:0]   weight_t;
  typedef logic signed [QuoW+1:0]   wsum_t;
  typedef logic signed [QuoW:0]     plo_t;
  typedef logic signed [QuoW-1:0]   phi_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [AccW-HalfQW-1:0] shifted_t;

  localparam weight_t WMax   = {1'b0, {(QuoW-1){1'b1}}};
  localparam weight_t WMin   = {1'b1, {(QuoW-1){1'b0}}};
  localparam wsum_t   WOne   = wsum_t'(1) <<< HalfQW;
  localparam coord_t  HMax   = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t  HMin   = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    weight_t  w1, w2;
    logic     det_zero;
    heights_t hgt;
  } b1_t;

  typedef struct packed {
    weight_t  w1, w2, w3;
    logic     det_zero;
    heights_t hgt;
  } b2_t;

  typedef struct packed {
    plo_t     lo1, lo2, lo3;
    phi_t     hi1, hi2, hi3;
    logic     det_zero;
  } b3_t;

  typedef struct packed {
    wide_t    m1, m2, m3;
    logic     det_zero;
  } b4_t;

  typedef struct packed {
    acc_t     acc;
    logic     det_zero;
  } b5_t;

  // Apply the quotient sign and clamp to the weight range
  function automatic weight_t sat_weight(logic [QuoW-1:0] quo, logic ovf, logic neg);
    weight_t r;
    if (ovf) begin
      r = neg ? WMin : WMax;
    end else if (neg) begin
      r = (quo > {1'b1, {(QuoW-1){1'b0}}}) ? WMin : weight_t'(-quo);
    end else begin
      r = quo[QuoW-1] ? WMax : weight_t'(quo);
    end
    return r;
  endfunction

  b1_t b1_d, b1_q;
  b2_t b2_d, b2_q;
  b3_t b3_d, b3_q;
  b4_t b4_d, b4_q;
  b5_t b5_d, b5_q;
  coord_t height_d, height_q;
  logic   vres_d, vres_q;
  logic [BlendStages-1:0] vld_q;
  wsum_t  w3_full;
  shifted_t shifted;

  // Saturate the two divided weights
  always_comb begin
    b1_d.w1       = sat_weight(in_i.quo1, in_i.ovf1, in_i.neg1);
    b1_d.w2       = sat_weight(in_i.quo2, in_i.ovf2, in_i.neg2);
    b1_d.det_zero = in_i.det_zero;
    b1_d.hgt      = in_i.hgt;
  end

  // Third weight is one minus the other two
  always_comb begin
    w3_full = WOne - wsum_t'(b1_q.w1) - wsum_t'(b1_q.w2);
    b2_d.w1 = b1_q.w1;
    b2_d.w2 = b1_q.w2;
    if (w3_full[QuoW+1:QuoW-1] == 3'b000 || w3_full[QuoW+1:QuoW-1] == 3'b111) begin
      b2_d.w3 = w3_full[QuoW-1:0];
    end else begin
      b2_d.w3 = w3_full[QuoW+1] ? WMin : WMax;
    end
    b2_d.det_zero = b1_q.det_zero;
    b2_d.hgt      = b1_q.hgt;
  end

  // Partial products: low weight half unsigned, high half signed
  always_comb begin
    b3_d.lo1 = plo_t'($signed({1'b0, b2_q.w1[HalfQW-1:0]})) * plo_t'(b2_q.hgt.ah);
    b3_d.lo2 = plo_t'($signed({1'b0, b2_q.w2[HalfQW-1:0]})) * plo_t'(b2_q.hgt.bh);
    b3_d.lo3 = plo_t'($signed({1'b0, b2_q.w3[HalfQW-1:0]})) * plo_t'(b2_q.hgt.ch);
    b3_d.hi1 = phi_t'($signed(b2_q.w1[QuoW-1:HalfQW])) * phi_t'(b2_q.hgt.ah);
    b3_d.hi2 = phi_t'($signed(b2_q.w2[QuoW-1:HalfQW])) * phi_t'(b2_q.hgt.bh);
    b3_d.hi3 = phi_t'($signed(b2_q.w3[QuoW-1:HalfQW])) * phi_t'(b2_q.hgt.ch);
    b3_d.det_zero = b2_q.det_zero;
  end

  // Recombine each weighted height
  always_comb begin
    b4_d.m1 = $signed({b3_q.hi1, {HalfQW{1'b0}}}) + wide_t'(b3_q.lo1);
    b4_d.m2 = $signed({b3_q.hi2, {HalfQW{1'b0}}}) + wide_t'(b3_q.lo2);
    b4_d.m3 = $signed({b3_q.hi3, {HalfQW{1'b0}}}) + wide_t'(b3_q.lo3);
    b4_d.det_zero = b3_q.det_zero;
  end

  // Sum the three terms
  always_comb begin
    b5_d.acc      = acc_t'(b4_q.m1) + acc_t'(b4_q.m2) + acc_t'(b4_q.m3);
    b5_d.det_zero = b4_q.det_zero;
  end

  // Drop the weight fraction, clamp to Q16.16, zero a degenerate triangle
  always_comb begin
    shifted = b5_q.acc[AccW-1:HalfQW];
    if (b5_q.det_zero) begin
      height_d = '0;
    end else if (shifted[AccW-HalfQW-1:CoordW-1] == '0 ||
                 shifted[AccW-HalfQW-1:CoordW-1] == '1) begin
      height_d = shifted[CoordW-1:0];
    end else begin
      height_d = shifted[AccW-HalfQW-1] ? HMin : HMax;
    end
    vres_d = !b5_q.det_zero;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BlendStages-2:0], in_valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    b1_q     <= b1_d;
    b2_q     <= b2_d;
    b3_q     <= b3_d;
    b4_q     <= b4_d;
    b5_q     <= b5_d;
    height_q <= height_d;
    vres_q   <= vres_d;
  end

  assign out_valid_o = vld_q[BlendStages-1];
  assign height_o    = height_q;
  assign valid_res_o = vres_q;

endmodule

// ===== rtl/barycentric_height_interpolator_top.sv =====
// Top level of the barycentric height interpolator.
`timescale 1ns / 1ps

// Takes one triangle and query point per cycle (busy_o is held low) and returns
// one result per start transfer, marked by done_o for a single cycle. The
// pipeline is the 64-step quotient chain of the divider, plus four front-end
// stages, one divider seed stage and six blend stages. The result cannot be
// held off, so sample it whenever done_o is high. A triangle whose x-z
// determinant is zero gives height 0 with valid_res_o low.
module barycentric_height_interpolator_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  bhi_pkg::coord_t vertex_a_x_i,
  input  bhi_pkg::coord_t vertex_a_h_i,
  input  bhi_pkg::coord_t vertex_a_z_i,
  input  bhi_pkg::coord_t vertex_b_x_i,
  input  bhi_pkg::coord_t vertex_b_h_i,
  input  bhi_pkg::coord_t vertex_b_z_i,
  input  bhi_pkg::coord_t vertex_c_x_i,
  input  bhi_pkg::coord_t vertex_c_h_i,
  input  bhi_pkg::coord_t vertex_c_z_i,
  input  bhi_pkg::coord_t query_x_i,
  input  bhi_pkg::coord_t query_z_i,
  output logic            done_o,
  output bhi_pkg::coord_t height_o,
  output logic            valid_res_o
);
  import bhi_pkg::*;

  tri_t     tri_in;
  logic     in_xfer;
  logic     front_vld;
  div_in_t  front_out;
  logic     div_vld;
  div_out_t div_out;

  // Gather the input transfer
  always_comb begin
    tri_in.ax = vertex_a_x_i;
    tri_in.ah = vertex_a_h_i;
    tri_in.az = vertex_a_z_i;
    tri_in.bx = vertex_b_x_i;
    tri_in.bh = vertex_b_h_i;
    tri_in.bz = vertex_b_z_i;
    tri_in.cx = vertex_c_x_i;
    tri_in.ch = vertex_c_h_i;
    tri_in.cz = vertex_c_z_i;
    tri_in.qx = query_x_i;
    tri_in.qz = query_z_i;
  end

  assign busy_o  = 1'b0;
  assign in_xfer = start_i && !busy_o;

  bhi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .in_i        (tri_in),
    .out_valid_o (front_vld),
    .out_o       (front_out)
  );

  bhi_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_vld),
    .in_i        (front_out),
    .out_valid_o (div_vld),
    .out_o       (div_out)
  );

  bhi_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_vld),
    .in_i        (div_out),
    .out_valid_o (done_o),
    .height_o    (height_o),
    .valid_res_o (valid_res_o)
  );

  // Every result traces back to an earlier start transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result without matching start transfer");

  // Degenerate triangle reports zero height
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !valid_res_o |-> height_o == '0)
    else $error("degenerate result carries nonzero height");

endmodule
